// ----- sv/ulp_pkg.sv -----
// Types, character codes and digit decoding shared by the literal parser.
package ulp_pkg;

    typedef enum logic [1:0] {
        PH_BLANK  = 2'd0,
        PH_PREFIX = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_BIN = 2'd2
    } t_base;

    localparam int unsigned ACC_W = 32;
    localparam int unsigned CNT_W = 6;

    typedef struct packed {
        t_phase             phase;
        t_base              base;
        logic [ACC_W-1:0]   acc;
        logic [CNT_W-1:0]   count;
        logic               err;
        logic               zero_seen;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:     PH_BLANK,
        base:      BASE_DEC,
        acc:       '0,
        count:     '0,
        err:       1'b0,
        zero_seen: 1'b0
    };

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LB    = 8'h62;

    localparam logic [CNT_W-1:0] LIMIT_DEC = 6'd10;
    localparam logic [CNT_W-1:0] LIMIT_HEX = 6'd8;
    localparam logic [CNT_W-1:0] LIMIT_BIN = 6'd32;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    // Decode one character as a digit of the given base.
    function automatic t_digit digit_of(input logic [7:0] c, input t_base base);
        t_digit d;
        logic [7:0] diff;
        d    = '{ok: 1'b0, val: 4'd0};
        diff = 8'd0;
        if (base == BASE_BIN) begin
            if (c == CH_ZERO || c == CH_ONE) begin
                d.ok  = 1'b1;
                d.val = {3'd0, c[0]};
            end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            diff  = c - CH_ZERO;
            d.ok  = 1'b1;
            d.val = diff[3:0];
        end else if (base == BASE_HEX && c >= CH_UA && c <= CH_UF) begin
            diff  = c - CH_UA + 8'd10;
            d.ok  = 1'b1;
            d.val = diff[3:0];
        end else if (base == BASE_HEX && c >= CH_LA && c <= CH_LF) begin
            diff  = c - CH_LA + 8'd10;
            d.ok  = 1'b1;
            d.val = diff[3:0];
        end
        return d;
    endfunction

endpackage

// ----- sv/ulp_if.sv -----
// Valid/ready channels for characters in and parsed values out.
interface ulp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       final_char;

    modport source (output valid, output char_code, output final_char, input ready);
    modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface ulp_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] parsed_value;
    logic        value_ok;

    modport source (output valid, output parsed_value, output value_ok, input ready);
    modport sink   (input valid, input parsed_value, input value_ok, output ready);
endinterface

// ----- sv/ulp_next.sv -----
// Next parser state and end-of-literal result for one character.
module ulp_next (
    input  ulp_pkg::t_parse_state i_state,
    input  logic [7:0]            i_char,
    output ulp_pkg::t_parse_state o_state,
    output logic [31:0]           o_value,
    output logic                  o_ok
);

    ulp_pkg::t_parse_state s;
    ulp_pkg::t_base        tbase;
    ulp_pkg::t_digit       dig;
    logic                  take;
    logic [ulp_pkg::CNT_W-1:0] limit;
    logic [35:0]           prod;
    logic [36:0]           sum;
    logic [33:0]           acc_next;

    always_comb begin
        s     = i_state;
        tbase = i_state.base;
        take  = 1'b0;
        if (!i_state.err) begin
            unique case (i_state.phase)
                ulp_pkg::PH_BLANK: begin
                    if (i_char == ulp_pkg::CH_SPACE || i_char == ulp_pkg::CH_ZERO) begin
                        s.zero_seen = (i_char == ulp_pkg::CH_ZERO);
                    end else if (i_char == ulp_pkg::CH_LX || i_char == ulp_pkg::CH_UX) begin
                        s.base      = ulp_pkg::BASE_HEX;
                        s.phase     = ulp_pkg::PH_PREFIX;
                        s.zero_seen = 1'b0;
                    end else if (i_char == ulp_pkg::CH_LB || i_char == ulp_pkg::CH_UB) begin
                        s.base      = ulp_pkg::BASE_BIN;
                        s.phase     = ulp_pkg::PH_PREFIX;
                        s.zero_seen = 1'b0;
                    end else begin
                        s.base      = ulp_pkg::BASE_DEC;
                        s.zero_seen = 1'b0;
                        tbase       = ulp_pkg::BASE_DEC;
                        take        = 1'b1;
                    end
                end
                ulp_pkg::PH_PREFIX: begin
                    if (i_char == ulp_pkg::CH_ZERO) begin
                        s.zero_seen = 1'b1;
                    end else begin
                        take = 1'b1;
                    end
                end
                default: begin
                    take = 1'b1;
                end
            endcase
        end

        dig = ulp_pkg::digit_of(i_char, tbase);
        unique case (tbase)
            ulp_pkg::BASE_HEX: begin
                limit = ulp_pkg::LIMIT_HEX;
                prod  = {i_state.acc, 4'd0};
            end
            ulp_pkg::BASE_BIN: begin
                limit = ulp_pkg::LIMIT_BIN;
                prod  = {3'd0, i_state.acc, 1'b0};
            end
            default: begin
                limit = ulp_pkg::LIMIT_DEC;
                prod  = {1'b0, i_state.acc, 3'd0} + {3'd0, i_state.acc, 1'b0};
            end
        endcase
        sum      = {1'b0, prod} + {33'd0, dig.val};
        acc_next = sum[33:0];

        // Bad digit, too many digits or past 32 bits: flag and hold the value.
        if (take) begin
            if (!dig.ok || i_state.count >= limit || acc_next[33:32] != 2'b00) begin
                s.err = 1'b1;
            end else begin
                s.acc   = acc_next[31:0];
                s.count = i_state.count + 6'd1;
                s.phase = ulp_pkg::PH_DIGITS;
            end
        end

        if (s.err) begin
            o_ok = 1'b0;
        end else if (s.phase == ulp_pkg::PH_DIGITS) begin
            o_ok = 1'b1;
        end else begin
            o_ok = s.zero_seen;
        end
        o_value = (o_ok && s.phase == ulp_pkg::PH_DIGITS) ? s.acc : 32'd0;
        o_state = s;
    end

endmodule

// ----- sv/unsigned_literal_parser.sv -----
// Top level of the streaming unsigned literal parser.
//
// Usage:
//   i_char   carries one ASCII character per word (char_code) plus final_char,
//            which marks the last character of a literal.
//   o_result carries one word per literal: parsed_value and value_ok.
//            Non-final characters produce no result word.
//   Literals: leading spaces/zeros skipped; x/X selects hex, b/B binary,
//   else decimal. Errors give value_ok = 0 and parsed_value = 0.
// Timing:
//   A character is taken into the input register; when it advances, the
//   parser state and, for a final character, the result register are
//   updated from it. One character per cycle while no final character
//   waits for o_result; the state update is a combinational shift-add on
//   the 32-bit accumulator.
// Reset:
//   i_rst_n (synchronous, active low) clears both registers' valid bits
//   and returns the parser to the leading-blank phase.
// Stall:
//   While o_result waits, non-final characters keep flowing; a final
//   character holds in the input register until the result word drains.
module unsigned_literal_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ulp_char_if.sink           i_char,
    ulp_result_if.source       o_result
);

    // Input register.
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_char,  n_in_char;
    logic       r_in_final, n_in_final;

    // Parser state.
    ulp_pkg::t_parse_state r_state, n_state;
    ulp_pkg::t_parse_state step_state;

    // Result register.
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_value, n_out_value;
    logic        r_out_ok,    n_out_ok;

    logic [31:0] step_value;
    logic        step_ok;
    logic        advance;

    ulp_next u_next (
        .i_state (r_state),
        .i_char  (r_in_char),
        .o_state (step_state),
        .o_value (step_value),
        .o_ok    (step_ok)
    );

    // A final character needs a free result slot; others always advance.
    assign advance      = r_in_valid && (!r_in_final || !r_out_valid || o_result.ready);
    assign i_char.ready = !r_in_valid || advance;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_char   = r_in_char;
        n_in_final  = r_in_final;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_ok    = r_out_ok;

        // Drop the result word once taken.
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        if (advance) begin
            n_in_valid = 1'b0;
            if (r_in_final) begin
                // Start over on a fresh literal and present the result.
                n_state     = ulp_pkg::PARSE_RESET;
                n_out_valid = 1'b1;
                n_out_value = step_value;
                n_out_ok    = step_ok;
            end else begin
                n_state = step_state;
            end
        end

        if (i_char.valid && i_char.ready) begin
            n_in_valid = 1'b1;
            n_in_char  = i_char.char_code;
            n_in_final = i_char.final_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ulp_pkg::PARSE_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        r_in_char   <= n_in_char;
        r_in_final  <= n_in_final;
        r_out_value <= n_out_value;
        r_out_ok    <= n_out_ok;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.parsed_value = r_out_value;
    assign o_result.value_ok     = r_out_ok;

endmodule

// ----- tb/tb_unsigned_literal_parser.sv -----
// Self-checking testbench for the unsigned literal parser: char words in, value words out.
`timescale 1ns / 100ps

module tb_unsigned_literal_parser;
    import ulp_pkg::*;

    localparam int RANDOM_CHARS   = 1400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // One parsed literal as it leaves the block.
    typedef struct packed {
        logic [31:0] value;
        logic        ok;
    } t_parsed;

    // One directed literal; the expected word is typed in only where it is obvious.
    typedef struct {
        string   text;
        bit      typed;
        t_parsed want;
    } t_lit_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ulp_char_if   char_ch ();
    ulp_result_if res_ch ();

    unsigned_literal_parser u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_ch),
        .o_result (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Literal predictor: its own copy of the parse state, advanced once per
    // accepted char word and closed out on the final char of a literal.
    // ------------------------------------------------------------------
    t_phase      lit_phase;
    t_base       lit_base;
    logic [33:0] lit_acc;
    logic [5:0]  lit_ndig;
    bit          lit_bad;
    bit          lit_zero;

    t_parsed     pending_values [$];   // values still owed by the block
    logic [7:0]  lit_chars [$];        // random literal under construction

    int  mismatches     = 0;
    int  driven_chars   = 0;           // chars that the parser actually acted on
    int  literals_sent  = 0;
    int  values_checked = 0;
    int  values_ok      = 0;
    int  quiet_cycles   = 0;
    bit  steady         = 1'b0;        // no idling on either side while set

    function automatic void clear_literal();
        lit_phase = PH_BLANK;
        lit_base  = BASE_DEC;
        lit_acc   = '0;
        lit_ndig  = '0;
        lit_bad   = 1'b0;
        lit_zero  = 1'b0;
    endfunction

    // Value of a char as a digit of the current base, -1 when it is none.
    function automatic int char_digit(logic [7:0] c, t_base b);
        if (b == BASE_BIN) begin
            return (c == CH_ZERO || c == CH_ONE) ? int'(c - CH_ZERO) : -1;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c - CH_ZERO);
        end
        if (b == BASE_HEX && c >= CH_UA && c <= CH_UF) begin
            return int'(c - CH_UA) + 10;
        end
        if (b == BASE_HEX && c >= CH_LA && c <= CH_LF) begin
            return int'(c - CH_LA) + 10;
        end
        return -1;
    endfunction

    // Shift one digit into the accumulator; flag the literal on any overrun.
    function automatic void take_digit(logic [7:0] c);
        int          d;
        int          cap;
        logic [63:0] mult;
        logic [63:0] nxt;
        d = char_digit(c, lit_base);
        case (lit_base)
            BASE_HEX: begin
                cap  = int'(LIMIT_HEX);
                mult = 64'd16;
            end
            BASE_BIN: begin
                cap  = int'(LIMIT_BIN);
                mult = 64'd2;
            end
            default: begin
                cap  = int'(LIMIT_DEC);
                mult = 64'd10;
            end
        endcase
        if (d < 0 || int'(lit_ndig) + 1 > cap) begin
            lit_bad = 1'b1;
            return;
        end
        nxt = ({30'd0, lit_acc} * mult + 64'(d)) & 64'h3_FFFF_FFFF;
        if (nxt > 64'hFFFF_FFFF) begin
            lit_bad = 1'b1;
            return;
        end
        lit_acc   = nxt[33:0];
        lit_ndig  = lit_ndig + 6'd1;
        lit_phase = PH_DIGITS;
    endfunction

    function automatic void advance_literal(logic [7:0] c);
        if (lit_bad) begin
            return;
        end
        case (lit_phase)
            PH_BLANK: begin
                if (c == CH_SPACE || c == CH_ZERO) begin
                    lit_zero = (c == CH_ZERO);
                end else if (c == CH_LX || c == CH_UX) begin
                    lit_base  = BASE_HEX;
                    lit_phase = PH_PREFIX;
                    lit_zero  = 1'b0;
                end else if (c == CH_LB || c == CH_UB) begin
                    lit_base  = BASE_BIN;
                    lit_phase = PH_PREFIX;
                    lit_zero  = 1'b0;
                end else begin
                    // decimal: this char is already the first digit
                    lit_base = BASE_DEC;
                    lit_zero = 1'b0;
                    take_digit(c);
                end
            end
            PH_PREFIX: begin
                if (c == CH_ZERO) begin
                    lit_zero = 1'b1;
                end else begin
                    take_digit(c);
                end
            end
            default: begin
                take_digit(c);
            end
        endcase
    endfunction

    // Work out the value word for the literal just ended, then start over.
    function automatic t_parsed close_literal();
        t_parsed r;
        r = '0;
        if (!lit_bad) begin
            if (lit_phase == PH_DIGITS) begin
                r.ok    = 1'b1;
                r.value = lit_acc[31:0];
            end else begin
                // blanks only, or a prefix with nothing but zeros after it
                r.ok = lit_zero;
            end
        end
        clear_literal();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Char sender. Called at a falling edge, returns at a falling edge, so
    // valid stays high across back-to-back words without a glitch.
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic fin,
                             input bit typed, input t_parsed want);
        t_parsed pred;
        while (!steady && $urandom_range(99) < 20) begin
            char_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        char_ch.valid      <= 1'b1;
        char_ch.char_code  <= c;
        char_ch.final_char <= fin;
        @(posedge i_clk);
        while (!char_ch.ready) begin
            @(posedge i_clk);
        end
        // chars after an error are ignored by the parser and do not count
        if (!lit_bad) begin
            driven_chars++;
        end
        advance_literal(c);
        if (fin) begin
            pred = close_literal();
            pending_values.push_back(typed ? want : pred);
            literals_sent++;
        end
        @(negedge i_clk);
    endtask

    // Hold off the sender until every owed value word has come back.
    task automatic drain_values();
        char_ch.valid <= 1'b0;
        while (pending_values.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_char(string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // Build one random literal: mostly well-formed decimal, hex and binary
    // with random digits, some blanks-only strings, raw noise, and a share of
    // well-formed strings broken by a stray byte or a trailing space.
    function automatic void build_literal();
        int    kind;
        int    n;
        string near_top;
        kind     = $urandom_range(99);
        near_top = "42949672";
        lit_chars.delete();
        if (kind < 80) begin
            repeat ($urandom_range(3)) lit_chars.push_back(pick_char(" 0"));
        end
        if (kind < 30) begin
            if ($urandom_range(99) < 20) begin
                // straddle the 32-bit ceiling
                for (int i = 0; i < near_top.len(); i++) begin
                    lit_chars.push_back(near_top[i]);
                end
                repeat (2) lit_chars.push_back(pick_char("0123456789"));
            end else begin
                n = ($urandom_range(9) == 0) ? 11 : $urandom_range(10, 1);
                lit_chars.push_back(pick_char("123456789"));
                repeat (n - 1) lit_chars.push_back(pick_char("0123456789"));
            end
        end else if (kind < 55) begin
            lit_chars.push_back(pick_char("xX"));
            repeat ($urandom_range(2)) lit_chars.push_back(CH_ZERO);
            n = ($urandom_range(99) < 8) ? 0 :
                ($urandom_range(9) == 0) ? 9 : $urandom_range(8, 1);
            repeat (n) lit_chars.push_back(pick_char("0123456789abcdefABCDEF"));
        end else if (kind < 80) begin
            lit_chars.push_back(pick_char("bB"));
            repeat ($urandom_range(2)) lit_chars.push_back(CH_ZERO);
            n = ($urandom_range(99) < 8) ? 0 :
                ($urandom_range(9) == 0) ? 33 : $urandom_range(32, 1);
            repeat (n) lit_chars.push_back(pick_char("01"));
        end else if (kind < 90) begin
            repeat ($urandom_range(5, 1)) lit_chars.push_back(pick_char(" 0"));
        end else begin
            repeat ($urandom_range(5, 1)) lit_chars.push_back(8'($urandom_range(255)));
        end
        if (kind < 80 && $urandom_range(99) < 12) begin
            if ($urandom_range(1) == 0) begin
                lit_chars[$urandom_range(lit_chars.size() - 1)] = 8'($urandom_range(255));
            end else begin
                lit_chars.push_back(CH_SPACE);
            end
        end
    endfunction

    // Directed literals: edge values, every base, every special case.
    t_lit_row directed_rows [20] = '{
        '{"0",          1'b1, '{32'd0,        1'b1}},
        '{" ",          1'b1, '{32'd0,        1'b0}},   // blanks ending in a space
        '{"0 ",         1'b1, '{32'd0,        1'b0}},
        '{"x",          1'b1, '{32'd0,        1'b0}},   // prefix, nothing after it
        '{"b",          1'b1, '{32'd0,        1'b0}},
        '{"X00",        1'b1, '{32'd0,        1'b1}},   // prefix then zeros only
        '{"b0",         1'b1, '{32'd0,        1'b1}},
        '{"4294967295", 1'b1, '{32'hFFFF_FFFF, 1'b1}},
        '{"4294967296", 1'b1, '{32'd0,        1'b0}},   // one past the top
        '{"xFFFFFFFF",  1'b1, '{32'hFFFF_FFFF, 1'b1}},
        '{"x123456789", 1'b1, '{32'd0,        1'b0}},   // too many hex digits
        '{"7 ",         1'b1, '{32'd0,        1'b0}},   // trailing space
        '{"7\377",      1'b1, '{32'd0,        1'b0}},
        '{"12a",        1'b1, '{32'd0,        1'b0}},
        '{"q123",       1'b1, '{32'd0,        1'b0}},   // bad first char, rest ignored
        '{"xaBf",       1'b0, '{32'd0,        1'b0}},
        '{"B101",       1'b0, '{32'd0,        1'b0}},
        '{"00012",      1'b0, '{32'd0,        1'b0}},
        '{" 0 0x1f",    1'b0, '{32'd0,        1'b0}},
        '{"x0010",      1'b0, '{32'd0,        1'b0}}
    };

    // ------------------------------------------------------------------
    // Value receiver: random backpressure, applied at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        res_ch.ready <= steady || ($urandom_range(99) >= 20);
    end

    // Check each accepted value word against the oldest owed one.
    always @(posedge i_clk) begin
        t_parsed exp_word;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            values_checked++;
            if (res_ch.value_ok) begin
                values_ok++;
            end
            if (pending_values.size() == 0) begin
                mismatches++;
                $display("%0t: value word %h ok=%b with no literal pending",
                         $time, res_ch.parsed_value, res_ch.value_ok);
            end else begin
                exp_word = pending_values.pop_front();
                if (res_ch.parsed_value !== exp_word.value) begin
                    mismatches++;
                    $display("%0t: parsed_value expected %h, actual %h",
                             $time, exp_word.value, res_ch.parsed_value);
                end
                if (res_ch.value_ok !== exp_word.ok) begin
                    mismatches++;
                    $display("%0t: value_ok expected %b, actual %b",
                             $time, exp_word.ok, res_ch.value_ok);
                end
            end
        end
    end

    // Stop a hung run: too long with no word moving on either channel.
    always @(posedge i_clk) begin
        if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles, %0d values owed",
                     $time, quiet_cycles, pending_values.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int random_base;
        int lit_index;
        t_parsed no_want;
        no_want            = '0;
        i_rst_n            = 1'b0;
        char_ch.valid      = 1'b0;
        char_ch.char_code  = 8'd0;
        char_ch.final_char = 1'b0;
        res_ch.ready       = 1'b0;
        clear_literal();

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed literals first.
        foreach (directed_rows[r]) begin
            for (int i = 0; i < directed_rows[r].text.len(); i++) begin
                send_char(directed_rows[r].text[i], i == directed_rows[r].text.len() - 1,
                          directed_rows[r].typed, directed_rows[r].want);
            end
        end
        drain_values();

        // Random literals, with one calm stretch and one more full drain.
        random_base = driven_chars;
        lit_index   = 0;
        while (driven_chars - random_base < RANDOM_CHARS) begin
            steady = (lit_index >= 120 && lit_index < 200);
            if (lit_index == 260) begin
                drain_values();
            end
            build_literal();
            foreach (lit_chars[i]) begin
                send_char(lit_chars[i], i == lit_chars.size() - 1, 1'b0, no_want);
            end
            lit_index++;
        end
        steady = 1'b0;
        char_ch.valid <= 1'b0;

        // Let the last values come home, then idle before the report.
        while (pending_values.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d literals (%0d live chars) in decimal, hex and binary forms.",
                 literals_sent, driven_chars);
        $display("Checked %0d values: %0d accepted, %0d rejected.",
                 values_checked, values_ok, values_checked - values_ok);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
